// ----- sv/lzo_pkg.sv -----
// Shared types and constants for the LZO1X block decompressor.
package lzo_pkg;

    localparam int unsigned CntW         = 27;
    localparam int unsigned AccW         = 32;
    localparam int unsigned DefWindow    = 65536;
    localparam logic [CntW-1:0] LimitRst = 27'd65536;

    localparam logic [7:0]  FirstLitBias = 8'd17;
    localparam logic [16:0] M1LongBase   = 17'h0800;
    localparam logic [16:0] M4Base       = 17'h4000;
    localparam logic [AccW-1:0] ExtStep  = 32'd255;
    localparam logic [AccW-1:0] M3ExtBase = 32'd31;
    localparam logic [AccW-1:0] LitExtBase = 32'd15;
    localparam logic [AccW-1:0] M4ExtBase = 32'd7;
    localparam logic [AccW-1:0] AccCap   = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_RUN     = 3'd0,
        ST_DONE_C  = 3'd1,
        ST_TRUNC   = 3'd2,
        ST_BADDIST = 3'd3,
        ST_OVERRUN = 3'd4,
        ST_TRAILB  = 3'd5,
        ST_ORDER   = 3'd6
    } t_status;

    typedef enum logic [18:0] {
        P_FIRST  = 19'h00001,
        P_OPA    = 19'h00002,
        P_OPB    = 19'h00004,
        P_OPC    = 19'h00008,
        P_LITEXT = 19'h00010,
        P_LIT    = 19'h00020,
        P_TRAIL  = 19'h00040,
        P_M1L    = 19'h00080,
        P_M1S    = 19'h00100,
        P_M2     = 19'h00200,
        P_M3EXT  = 19'h00400,
        P_M3D0   = 19'h00800,
        P_M3D1   = 19'h01000,
        P_M4EXT  = 19'h02000,
        P_M4D0   = 19'h04000,
        P_M4D1   = 19'h08000,
        P_COPY   = 19'h10000,
        P_DONE   = 19'h20000,
        P_ERR    = 19'h40000
    } t_pstate;

    // request from the parser to the history stage
    typedef struct packed {
        logic            valid;
        logic            wr;      // a byte is appended to history
        logic            rd;      // the byte comes from history (copy pull)
        logic [7:0]      lit;
        logic            copy_pending;
        t_status         status;
        logic [CntW-1:0] count;   // count after this item
    } t_hreq;

endpackage

// ----- sv/lzo_hist.sv -----
// History ring and output register of the LZO1X block decompressor.
module lzo_hist
    import lzo_pkg::*;
#(
    parameter int unsigned WINDOW_BYTES = DefWindow
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_hreq                           i_req,
    input  logic [$clog2(WINDOW_BYTES)-1:0] i_wr_addr,
    input  logic [$clog2(WINDOW_BYTES)-1:0] i_rd_addr,
    output logic                            o_busy,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic                            o_has_byte,
    output logic [7:0]                      o_out_byte,
    output logic                            o_copy_pending,
    output logic [2:0]                      o_status,
    output logic [CntW-1:0]                 o_out_count
);
    localparam int unsigned AW = $clog2(WINDOW_BYTES);

    logic [7:0] r_mem [WINDOW_BYTES];
    logic [7:0] r_rd_data;
    logic [7:0] r_wr_data;
    logic       r_fwd;          // read hits the entry written last cycle
    logic [AW-1:0] r_last_wa;

    // stage 1: memory read in flight
    logic  r_s1_v;
    t_hreq r_s1;
    // output register
    logic  r_o_v;
    t_hreq r_o;
    logic [7:0] r_o_byte;

    logic [7:0] s1_byte;
    logic       wr_now;
    logic [AW-1:0] n_wa;

    assign s1_byte = !r_s1.rd ? r_s1.lit : (r_fwd ? r_wr_data : r_rd_data);
    // a stage stalls only if the output is full and not taken
    assign o_busy  = r_s1_v && r_o_v && !i_ready;
    assign wr_now  = r_s1_v && !o_busy && r_s1.wr;

    always_ff @(posedge i_clk) begin
        if (!o_busy) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_fwd     <= wr_now && (r_last_wa == i_rd_addr);
            r_wr_data <= s1_byte;
        end
        if (wr_now) begin
            r_mem[r_last_wa] <= s1_byte;
        end
    end

    // write address of the item in stage 1 is captured with it
    assign n_wa = i_wr_addr;
    always_ff @(posedge i_clk) begin
        if (!o_busy) begin
            r_last_wa <= n_wa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (!o_busy) begin
                r_s1_v <= i_req.valid;
                if (r_s1_v) begin
                    r_o_v <= 1'b1;
                end else if (i_ready) begin
                    r_o_v <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_busy) begin
            r_s1 <= i_req;
            if (r_s1_v) begin
                r_o      <= r_s1;
                r_o_byte <= s1_byte;
            end
        end
    end

    assign o_valid        = r_o_v;
    assign o_has_byte     = r_o.wr;
    assign o_out_byte     = r_o.wr ? r_o_byte : 8'd0;
    assign o_copy_pending = r_o.copy_pending;
    assign o_status       = r_o.status;
    assign o_out_count    = r_o.count;

    a_fwd_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd && r_s1_v && !$past(o_busy) |-> $past(wr_now))
        else $error("forward without a preceding write");
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> r_s1_v && r_o_v)
        else $error("stalled stage lost its item");
    a_byte_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && !r_o.wr |-> o_out_byte == 8'd0)
        else $error("byte without flag");
endmodule

// ----- sv/lzo1x_block_decompressor_top.sv -----
// Top level of the LZO1X block decompressor: token parser and handshakes.
//
// Usage: each input item either feeds one compressed byte (i_req_type 0) or
// pulls one byte of an armed match copy (i_req_type 1). Every accepted item
// yields exactly one result item: a literal or copied byte when has_byte is
// set, plus copy_pending, status and the running output count.
// Config: one write-only channel sets output_limit (reset 65536); write it
// only while the block is idle.
// Pipeline: an accepted item passes the history read stage and then the
// output register before its result is shown.
// Throughput: one item per cycle while not stalled; the history ring is one
// 8-bit memory with one read and one write port, and a pull that reads the
// byte being written by the previous item is served by a forward path.
// Reset: synchronous, active low; the parser returns to the first-byte
// state, counters clear, the ring contents are left as they are.
// Stall: while the receiver holds i_out_ready low the output register keeps
// its item and the read stage still takes one more; once both hold an item
// input ready drops in the same cycle; no item is lost or repeated.
// Errors are sticky until reset; items after the failing one report has_byte 0.
module lzo1x_block_decompressor_top
    import lzo_pkg::*;
#(
    parameter int unsigned WINDOW_BYTES = DefWindow
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [CntW-1:0] i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_req_type,
    input  logic [7:0]      i_in_byte,
    input  logic            i_in_last,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_has_byte,
    output logic [7:0]      o_out_byte,
    output logic            o_copy_pending,
    output logic [2:0]      o_status,
    output logic [CntW-1:0] o_out_count
);
    localparam int unsigned AW = $clog2(WINDOW_BYTES);

    logic [CntW-1:0] r_limit;
    t_pstate         r_ps, n_ps;
    logic [7:0]      r_op, n_op;
    logic [AccW-1:0] r_acc, n_acc;
    logic [15:0]     r_dist, n_dist;
    logic [1:0]      r_trail, n_trail;
    t_status         r_fst, n_fst;
    logic [CntW-1:0] r_wc, n_wc;

    logic   busy, acc;
    t_hreq  req;
    logic [CntW-1:0] room;
    logic [CntW-1:0] room_chk;   // room seen by a literal run armed this item
    logic [AccW-1:0] ext_v;
    logic            ext_done;
    logic [AccW-1:0] ext_base;
    logic [16:0]     cdist;
    logic [AccW-1:0] clen;
    logic            do_copy;
    logic [AccW-1:0] lits_n;
    t_pstate         lits_next;
    logic            do_lits;
    logic [15:0]     le;
    logic [16:0]     m4d;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !busy;
    assign acc         = i_in_valid && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitRst;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    assign room = (r_wc >= r_limit) ? '0 : r_limit - r_wc;

    always_comb begin
        ext_base = (r_ps == P_LITEXT) ? LitExtBase :
                   (r_ps == P_M3EXT) ? M3ExtBase : M4ExtBase;
        ext_done = (i_in_byte != 8'd0);
        if (ext_done) begin
            ext_v = r_acc + ext_base + {24'd0, i_in_byte};
        end else begin
            ext_v = (r_acc < AccCap) ? r_acc + ExtStep : r_acc;
        end
    end

    always_comb begin
        n_ps = r_ps; n_op = r_op; n_acc = r_acc; n_dist = r_dist;
        n_trail = r_trail; n_fst = r_fst; n_wc = r_wc;
        req = '0;
        room_chk = room;
        do_copy = 1'b0; cdist = '0; clen = '0;
        do_lits = 1'b0; lits_n = '0; lits_next = P_LIT;
        le = {i_in_byte, r_dist[7:0]};
        m4d = {2'd0, r_op[3], 14'd0} + {3'd0, le[15:2]};

        if (r_ps == P_ERR) begin
            // sticky
        end else if (r_ps == P_DONE) begin
            n_fst = i_req_type ? ST_ORDER : ST_TRAILB;
            n_ps = P_ERR;
        end else if (i_req_type) begin
            if (r_ps != P_COPY) begin
                n_fst = ST_ORDER; n_ps = P_ERR;
            end else begin
                req.wr = 1'b1; req.rd = 1'b1;
                n_wc = r_wc + 1'b1;
                n_acc = r_acc - 1'b1;
                // trailing literals are checked against the room after this byte
                room_chk = (room == '0) ? '0 : room - 1'b1;
                if (r_acc == 32'd1) begin
                    if (r_trail == 2'd0) n_ps = P_OPA;
                    else begin
                        do_lits = 1'b1; lits_n = {30'd0, r_trail}; lits_next = P_TRAIL;
                    end
                end
            end
        end else if (r_ps == P_COPY) begin
            n_fst = ST_ORDER; n_ps = P_ERR;
        end else begin
            priority case (1'b1)
                (r_ps == P_FIRST) && (i_in_byte > FirstLitBias): begin
                    do_lits = 1'b1;
                    lits_n = {24'd0, i_in_byte - FirstLitBias};
                    lits_next = (lits_n < 32'd4) ? P_TRAIL : P_LIT;
                end
                (r_ps == P_FIRST) || (r_ps == P_OPA) || (r_ps == P_OPB)
                        || (r_ps == P_OPC): begin
                    n_op = i_in_byte;
                    if (i_in_byte >= 8'd64) begin
                        n_trail = i_in_byte[1:0];
                        n_acc = {29'd0, i_in_byte[7:5]} + 32'd1;
                        n_ps = P_M2;
                    end else if (i_in_byte >= 8'd32) begin
                        n_acc = (i_in_byte[4:0] != 0) ? {27'd0, i_in_byte[4:0]} + 32'd2 : '0;
                        n_ps = (i_in_byte[4:0] != 0) ? P_M3D0 : P_M3EXT;
                    end else if (i_in_byte >= 8'd16) begin
                        n_acc = (i_in_byte[2:0] != 0) ? {29'd0, i_in_byte[2:0]} + 32'd2 : '0;
                        n_ps = (i_in_byte[2:0] != 0) ? P_M4D0 : P_M4EXT;
                    end else if (r_ps == P_OPA || r_ps == P_FIRST) begin
                        if (i_in_byte == 8'd0) begin
                            n_acc = '0; n_ps = P_LITEXT;
                        end else begin
                            do_lits = 1'b1; lits_n = {24'd0, i_in_byte} + 32'd3;
                        end
                    end else begin
                        n_trail = i_in_byte[1:0];
                        n_ps = (r_ps == P_OPB) ? P_M1L : P_M1S;
                    end
                end
                r_ps == P_LITEXT: begin
                    n_acc = ext_v;
                    if (ext_done) begin
                        do_lits = 1'b1; lits_n = ext_v + 32'd3;
                    end
                end
                (r_ps == P_LIT) || (r_ps == P_TRAIL): begin
                    req.wr = 1'b1; req.lit = i_in_byte;
                    n_wc = r_wc + 1'b1;
                    n_acc = r_acc - 1'b1;
                    if (r_acc == 32'd1) n_ps = (r_ps == P_LIT) ? P_OPB : P_OPC;
                end
                r_ps == P_M1L: begin
                    do_copy = 1'b1; clen = 32'd3;
                    cdist = 17'd1 + M1LongBase + {11'd0, r_op[7:2]} + {7'd0, i_in_byte, 2'd0};
                end
                r_ps == P_M1S: begin
                    do_copy = 1'b1; clen = 32'd2;
                    cdist = 17'd1 + {11'd0, r_op[7:2]} + {7'd0, i_in_byte, 2'd0};
                end
                r_ps == P_M2: begin
                    do_copy = 1'b1; clen = r_acc;
                    cdist = 17'd1 + {14'd0, r_op[4:2]} + {6'd0, i_in_byte, 3'd0};
                end
                (r_ps == P_M3EXT) || (r_ps == P_M4EXT): begin
                    n_acc = ext_v;
                    if (ext_done) begin
                        n_acc = ext_v + 32'd2;
                        n_ps = (r_ps == P_M3EXT) ? P_M3D0 : P_M4D0;
                    end
                end
                (r_ps == P_M3D0) || (r_ps == P_M4D0): begin
                    n_dist = {8'd0, i_in_byte};
                    n_trail = i_in_byte[1:0];
                    n_ps = (r_ps == P_M3D0) ? P_M3D1 : P_M4D1;
                end
                r_ps == P_M3D1: begin
                    do_copy = 1'b1; clen = r_acc;
                    cdist = 17'd1 + {3'd0, le[15:2]};
                end
                r_ps == P_M4D1: begin
                    if (m4d == 17'd0) begin
                        n_fst = ST_DONE_C; n_ps = P_DONE;
                    end else begin
                        do_copy = 1'b1; clen = r_acc;
                        cdist = m4d + M4Base;
                    end
                end
                default: begin
                    n_fst = ST_ORDER; n_ps = P_ERR;
                end
            endcase
        end

        if (do_lits) begin
            if (lits_n > {5'd0, room_chk}) begin
                n_fst = ST_OVERRUN; n_ps = P_ERR;
            end else begin
                n_acc = lits_n; n_ps = lits_next;
            end
        end
        if (do_copy) begin
            if ({15'd0, cdist} > {5'd0, r_wc}) begin
                n_fst = ST_BADDIST; n_ps = P_ERR;
            end else if (clen > {5'd0, room}) begin
                n_fst = ST_OVERRUN; n_ps = P_ERR;
            end else begin
                n_dist = cdist[15:0]; n_acc = clen; n_ps = P_COPY;
            end
        end
        if (!i_req_type && r_ps != P_ERR && r_ps != P_DONE && r_ps != P_COPY
                && i_in_last && n_ps != P_DONE && n_ps != P_ERR) begin
            n_fst = ST_TRUNC; n_ps = P_ERR;
        end

        req.valid = acc;
        req.copy_pending = (n_ps == P_COPY);
        req.status = n_fst;
        req.count = n_wc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps <= P_FIRST; r_op <= '0; r_acc <= '0; r_dist <= '0;
            r_trail <= '0; r_fst <= ST_RUN; r_wc <= '0;
        end else if (acc) begin
            r_ps <= n_ps; r_op <= n_op; r_acc <= n_acc; r_dist <= n_dist;
            r_trail <= n_trail; r_fst <= n_fst; r_wc <= n_wc;
        end
    end

    logic [CntW-1:0] rd_full;
    assign rd_full = r_wc - {11'd0, r_dist};

    lzo_hist #(.WINDOW_BYTES(WINDOW_BYTES)) u_hist (
        .i_clk, .i_rst_n,
        .i_req          (req),
        .i_wr_addr      (r_wc[AW-1:0]),
        .i_rd_addr      (rd_full[AW-1:0]),
        .o_busy         (busy),
        .i_ready        (i_out_ready),
        .o_valid        (o_out_valid),
        .o_has_byte, .o_out_byte, .o_copy_pending, .o_status, .o_out_count
    );

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_ps))
        else $error("parser state not one-hot");
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ps == P_ERR |=> r_ps == P_ERR && $stable(r_wc))
        else $error("error not sticky");
    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ps == P_COPY |-> r_acc != '0)
        else $error("copy armed with zero length");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |=> $stable(r_wc))
        else $error("count moved without an item");
endmodule
